// ===== rtl/itrd_pkg.sv =====
// ============================================================================
// itrd_pkg: shared types and constants of the inverse-time rate scheduler
// Command codes, register indexes, fixed field widths, reset values and the
// command bundle that the controller drives into the datapath.
// ============================================================================
package itrd_pkg;

  // Fixed field widths.
  localparam int unsigned CmdW      = 2;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned DecayW    = 32;
  localparam int unsigned SampleInW = 32;
  localparam int unsigned EpochW    = 16;
  localparam int unsigned MulW      = 32;

  // Register reset values.
  localparam longint unsigned RstBaseRate    = 65536;
  localparam longint unsigned RstDecay       = 0;
  localparam longint unsigned RstMinImpr     = 1;
  localparam longint unsigned RstPatience    = 1;
  localparam longint unsigned RstInitError   = 6553600;
  localparam longint unsigned RstInitSamples = 0;
  localparam longint unsigned RstEpochLimit  = 0;
  localparam longint unsigned RstLimitEnable = 1;

  typedef enum logic [CmdW-1:0] {
    CMD_RESTART = 2'd0,
    CMD_EPOCH   = 2'd1,
    CMD_SAMPLES = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BASE_RATE      = 3'd0,
    REG_DECAY          = 3'd1,
    REG_MIN_IMPR       = 3'd2,
    REG_PATIENCE       = 3'd3,
    REG_INITIAL_ERROR  = 3'd4,
    REG_INITIAL_SAMPLE = 3'd5,
    REG_EPOCH_LIMIT    = 3'd6,
    REG_LIMIT_ENABLE   = 3'd7
  } reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic restart;     // reload schedule state
    logic epoch;       // apply an epoch-end item
    logic add;         // add the sample count (saturating)
    logic mul_lo;      // low word of samples times decay
    logic mul_hi;      // high word of samples times decay
    logic div_init;    // form the denominator and seed the divider
    logic div_step;    // one restoring division step
    logic div_finish;  // last step: write the new rate
    logic load_out;    // copy the current rate into the output register
  } dp_cmd_t;

endpackage

// ===== rtl/itrd_in_if.sv =====
// ============================================================================
// itrd_in_if: input item channel
// Valid/ready channel carrying one scheduler command and its operands.
// ============================================================================
interface itrd_in_if #(
  parameter int unsigned ERR_W = 24
);
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [ERR_W-1:0]   epoch_error;
  logic [31:0]        sample_count;

  modport source (output valid, output cmd, output epoch_error, output sample_count,
                  input ready);
  modport sink   (input valid, input cmd, input epoch_error, input sample_count,
                  output ready);
endinterface

// ===== rtl/itrd_out_if.sv =====
// ============================================================================
// itrd_out_if: result channel
// Valid/ready channel carrying the current rate and the stopped flag.
// ============================================================================
interface itrd_out_if #(
  parameter int unsigned ERR_W = 24
);
  logic             valid;
  logic             ready;
  logic [ERR_W-1:0] rate;
  logic             stopped;

  modport source (output valid, output rate, output stopped, input ready);
  modport sink   (input valid, input rate, input stopped, output ready);
endinterface

// ===== rtl/itrd_cfg_if.sv =====
// ============================================================================
// itrd_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and the data to write.
// ============================================================================
interface itrd_cfg_if #(
  parameter int unsigned DATA_W = 48
);
  logic              valid;
  logic              ready;
  logic [2:0]        index;
  logic [DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/itrd_ctrl.sv =====
// ============================================================================
// itrd_ctrl: sequencing controller
// Accepts items, steps the datapath through the multiply and divide
// sequence of a samples item, and owns the result valid flag.
// ============================================================================
module itrd_ctrl #(
  parameter int unsigned ERR_W = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_cmd_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output itrd_pkg::dp_cmd_t dp_cmd_o
);
  import itrd_pkg::*;

  localparam int unsigned CntW = $clog2(ERR_W);
  localparam logic [CntW-1:0] LastStep = CntW'(ERR_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_TOP,
    ST_DIV,
    ST_RESP
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic            out_free;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    dp_cmd_o            = '0;
    dp_cmd_o.restart    = accept && (in_cmd_i == CMD_RESTART);
    dp_cmd_o.epoch      = accept && (in_cmd_i == CMD_EPOCH);
    dp_cmd_o.add        = accept && (in_cmd_i == CMD_SAMPLES);
    dp_cmd_o.mul_lo     = (state_q == ST_MUL_LO);
    dp_cmd_o.mul_hi     = (state_q == ST_MUL_HI);
    dp_cmd_o.div_init   = (state_q == ST_TOP);
    dp_cmd_o.div_step   = (state_q == ST_DIV);
    dp_cmd_o.div_finish = (state_q == ST_DIV) && (cnt_q == LastStep);
    dp_cmd_o.load_out   = (state_q == ST_RESP) && out_free;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (in_cmd_i == CMD_SAMPLES) ? ST_MUL_LO : ST_RESP;
        end
      end
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_TOP;
      ST_TOP: begin
        state_d = ST_DIV;
        cnt_d   = '0;
      end
      ST_DIV: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == LastStep) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/itrd_dpath.sv =====
// ============================================================================
// itrd_dpath: scheduler datapath
// Configuration registers, schedule state, a shared 32x32 multiplier and a
// one-bit-per-cycle restoring divider for the decayed rate.
// ============================================================================
module itrd_dpath #(
  parameter int unsigned ERR_W = 24,
  parameter int unsigned SMP_W = 48
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  itrd_pkg::dp_cmd_t          dp_cmd_i,
  input  logic                       cfg_we_i,
  input  logic [itrd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [SMP_W-1:0]           cfg_data_i,
  input  logic [ERR_W-1:0]           epoch_error_i,
  input  logic [itrd_pkg::SampleInW-1:0] sample_count_i,
  output logic [ERR_W-1:0]           rate_o
);
  import itrd_pkg::*;

  localparam int unsigned NumW = ERR_W + 32;
  localparam int unsigned TopW = 2 * MulW + 1;

  // Configuration registers.
  logic [ERR_W-1:0]  base_rate_q, min_impr_q, init_error_q;
  logic [DecayW-1:0] decay_q;
  logic [EpochW-1:0] patience_q, epoch_limit_q;
  logic [SMP_W-1:0]  init_samples_q;
  logic              limit_en_q;

  // Schedule state.
  logic [ERR_W-1:0]  cur_rate_q, best_error_q;
  logic [EpochW-1:0] epoch_num_q, stall_cnt_q;
  logic [SMP_W-1:0]  samples_q;

  // Arithmetic registers.
  logic [2*MulW-1:0] p0_q, p1_q;
  logic [NumW-1:0]   den_q, rem_q;
  logic [ERR_W-1:0]  quo_q, rate_q;
  logic              zero_q;

  logic                    limit_hit, stalled;
  logic signed [ERR_W+1:0] diff;
  logic [EpochW-1:0]       stall_inc, epoch_inc;
  logic [ERR_W-1:0]        restart_rate;
  logic [SMP_W:0]          samp_sum;
  logic [SMP_W-1:0]        samp_sat;
  logic [MulW-1:0]         mul_a;
  logic [2*MulW-1:0]       mul_p;
  logic [TopW-1:0]         top;
  logic                    ovf;
  logic [NumW-1:0]         num;
  logic [NumW:0]           shifted, trial;
  logic [NumW-1:0]         rem_d;
  logic [ERR_W-1:0]        quo_d;

  // Epoch-end evaluation.
  always_comb begin
    limit_hit = limit_en_q && (epoch_num_q >= epoch_limit_q);
    diff      = $signed({2'b00, best_error_q}) - $signed({2'b00, epoch_error_i});
    stalled   = diff < $signed({2'b00, min_impr_q});
    stall_inc = (stall_cnt_q == '1) ? stall_cnt_q : stall_cnt_q + EpochW'(1);
    epoch_inc = (epoch_num_q == '1) ? epoch_num_q : epoch_num_q + EpochW'(1);
    restart_rate = (limit_en_q && (epoch_limit_q == '0)) ? '0 : base_rate_q;
  end

  // Saturating sample count.
  assign samp_sum = (SMP_W+1)'(samples_q) + (SMP_W+1)'(sample_count_i);
  assign samp_sat = samp_sum[SMP_W] ? '1 : samp_sum[SMP_W-1:0];

  // Shared multiplier: low word, then high word, of samples times decay.
  assign mul_a = dp_cmd_i.mul_hi ? MulW'(samples_q >> MulW) : samples_q[MulW-1:0];
  assign mul_p = mul_a * decay_q;

  // Denominator bits 32 and up; past the error width the rate is zero.
  assign top = TopW'(p0_q[2*MulW-1:MulW]) + TopW'(p1_q) + TopW'(1);
  assign ovf = |top[TopW-1:ERR_W];
  assign num = {base_rate_q, 32'b0};

  // Restoring division step.
  always_comb begin
    shifted = {rem_q, quo_q[ERR_W-1]};
    trial   = shifted - {1'b0, den_q};
    if (!trial[NumW]) begin
      rem_d = trial[NumW-1:0];
      quo_d = {quo_q[ERR_W-2:0], 1'b1};
    end else begin
      rem_d = shifted[NumW-1:0];
      quo_d = {quo_q[ERR_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_rate_q    <= ERR_W'(RstBaseRate);
      decay_q        <= DecayW'(RstDecay);
      min_impr_q     <= ERR_W'(RstMinImpr);
      patience_q     <= EpochW'(RstPatience);
      init_error_q   <= ERR_W'(RstInitError);
      init_samples_q <= SMP_W'(RstInitSamples);
      epoch_limit_q  <= EpochW'(RstEpochLimit);
      limit_en_q     <= 1'(RstLimitEnable);
      cur_rate_q     <= '0;
      best_error_q   <= ERR_W'(RstInitError);
      epoch_num_q    <= EpochW'(1);
      stall_cnt_q    <= '0;
      samples_q      <= SMP_W'(RstInitSamples);
    end else begin
      if (cfg_we_i) begin
        case (reg_e'(cfg_index_i))
          REG_BASE_RATE:      base_rate_q    <= cfg_data_i[ERR_W-1:0];
          REG_DECAY:          decay_q        <= cfg_data_i[DecayW-1:0];
          REG_MIN_IMPR:       min_impr_q     <= cfg_data_i[ERR_W-1:0];
          REG_PATIENCE:       patience_q     <= cfg_data_i[EpochW-1:0];
          REG_INITIAL_ERROR:  init_error_q   <= cfg_data_i[ERR_W-1:0];
          REG_INITIAL_SAMPLE: init_samples_q <= cfg_data_i;
          REG_EPOCH_LIMIT:    epoch_limit_q  <= cfg_data_i[EpochW-1:0];
          REG_LIMIT_ENABLE:   limit_en_q     <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (dp_cmd_i.restart) begin
        cur_rate_q   <= restart_rate;
        best_error_q <= init_error_q;
        epoch_num_q  <= EpochW'(1);
        stall_cnt_q  <= '0;
        samples_q    <= init_samples_q;
      end
      if (dp_cmd_i.epoch) begin
        if (limit_hit) begin
          cur_rate_q <= '0;
        end else begin
          if (epoch_error_i < best_error_q) begin
            best_error_q <= epoch_error_i;
          end
          if (stalled) begin
            stall_cnt_q <= stall_inc;
            if (stall_inc >= patience_q) begin
              cur_rate_q <= '0;
            end
          end else begin
            stall_cnt_q <= '0;
          end
          epoch_num_q <= epoch_inc;
        end
      end
      if (dp_cmd_i.add) begin
        samples_q <= samp_sat;
      end
      if (dp_cmd_i.div_finish) begin
        cur_rate_q <= zero_q ? '0 : quo_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.mul_lo) begin
      p0_q <= mul_p;
    end
    if (dp_cmd_i.mul_hi) begin
      p1_q <= mul_p;
    end
    if (dp_cmd_i.div_init) begin
      den_q  <= {top[ERR_W-1:0], p0_q[MulW-1:0]};
      zero_q <= ovf;
      rem_q  <= NumW'(num[NumW-1:ERR_W]);
      quo_q  <= num[ERR_W-1:0];
    end else if (dp_cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (dp_cmd_i.load_out) begin
      rate_q <= cur_rate_q;
    end
  end

  assign rate_o = rate_q;

endmodule

// ===== rtl/inverse_time_rate_decay.sv =====
// ============================================================================
// inverse_time_rate_decay: inverse-time learning-rate scheduler
// Learning-rate schedule for an on-chip trainer with inverse-time decay
// over trained samples, an epoch limit and early stopping on stalled error.
// ============================================================================
//
// Channel   Dir  Payload                                Transfer when
// in_i      in   cmd, epoch_error, sample_count         valid && ready
// out_o     out  rate, stopped                          valid && ready
// cfg_i     in   index, data                            valid && ready
//
// A restart, epoch-end or unused command goes from acceptance straight to the
// result state; a samples command first runs the multiplies and the divider.
// Reset loads the configuration and the schedule state with a zero current rate.
// One item is in flight at a time; a new item is accepted while a finished
// result waits in the output register, and the next result stalls behind it.
// Configuration writes are accepted in every cycle.
//
module inverse_time_rate_decay #(
  parameter int unsigned ERROR_WIDTH        = 24,
  parameter int unsigned SAMPLE_COUNT_WIDTH = 48
) (
  input logic        clk_i,
  input logic        rst_ni,
  itrd_in_if.sink    in_i,
  itrd_out_if.source out_o,
  itrd_cfg_if.sink   cfg_i
);
  import itrd_pkg::*;

  dp_cmd_t          dp_cmd;
  logic [ERROR_WIDTH-1:0] rate;

  // Configuration registers never back-pressure; the write lands in the
  // datapath at the transfer edge.
  assign cfg_i.ready = 1'b1;

  // The controller sequences the datapath: restart, epoch-end and the
  // saturating sample add happen at the acceptance edge; a samples item then
  // runs two multiplies, the denominator build and the division.
  itrd_ctrl #(
    .ERR_W (ERROR_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_cmd_i    (in_i.cmd),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .dp_cmd_o    (dp_cmd)
  );

  // The datapath holds the registers, the schedule state and the
  // arithmetic; the output rate register is loaded when the result slot
  // is free.
  itrd_dpath #(
    .ERR_W (ERROR_WIDTH),
    .SMP_W (SAMPLE_COUNT_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .dp_cmd_i       (dp_cmd),
    .cfg_we_i       (cfg_i.valid),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .epoch_error_i  (in_i.epoch_error),
    .sample_count_i (in_i.sample_count),
    .rate_o         (rate)
  );

  // A zero rate means training has stopped.
  assign out_o.rate    = rate;
  assign out_o.stopped = (rate == '0);

  // The output register is never overwritten while it holds a result that
  // has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.load_out |-> (!out_o.valid || out_o.ready))
    else $error("result register overwritten before transfer");

  // The divider never runs while a new item could be accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.div_step |-> !in_i.ready)
    else $error("input accepted while the divider is busy");

  // An accepted samples item starts the multiply sequence next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (in_i.cmd == CMD_SAMPLES)) |=> dp_cmd.mul_lo)
    else $error("samples item did not start the multiply");

  // The final division step is followed by the result hand-off, not by
  // acceptance of another item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.div_finish |=> !in_i.ready)
    else $error("new item accepted before the rate was delivered");

endmodule
